[hdl/nearest_member_search_assert.svh]
// assertion macros for the nearest member search block
`ifndef NEAREST_MEMBER_SEARCH_ASSERT_SVH
`define NEAREST_MEMBER_SEARCH_ASSERT_SVH

// same-cycle implication
`define NMS_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NMS_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/nms_pkg.sv]
// shared types and constants for the nearest member search block
`timescale 1ns / 1ps
`default_nettype none
package nms_pkg;

   localparam int MAX_MEMBERS   = 64;
   localparam int MAX_DIMS      = 16;
   localparam int COORD_BITS    = 16;

   localparam int MEMBER_IDX_W  = $clog2(MAX_MEMBERS);
   localparam int DIM_IDX_W     = $clog2(MAX_DIMS);
   localparam int MEM_ADDR_W    = MEMBER_IDX_W + DIM_IDX_W;
   localparam int MEM_DEPTH     = MAX_MEMBERS * MAX_DIMS;
   localparam int COUNT_W       = 7;
   localparam int DCOUNT_W      = 5;
   localparam int MODE_W        = 2;
   localparam int DIFF_W        = COORD_BITS + 1;
   localparam int SQ_W          = 2 * DIFF_W;
   localparam int DIST_W        = 37;
   localparam int DRAIN_W       = 2;
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int REQ_DATA_W    = 32;
   localparam int RSP_DATA_W    = 48;

   localparam logic [DRAIN_W-1:0] DRAIN_LAST = 2'd2;

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD_MEMBER = 2'd0,
      MODE_LOAD_QUERY  = 2'd1,
      MODE_SEARCH      = 2'd2,
      MODE_NONE        = 2'd3
   } mode_type;

   typedef enum logic {
      REG_MEMBER_COUNT    = 1'b0,
      REG_DIMENSION_COUNT = 1'b1
   } reg_index_type;

   // tag that travels with each member coordinate read
   typedef struct packed {
      logic                    valid;
      logic                    first_dim;
      logic                    last_dim;
      logic                    is_start;
      logic [MEMBER_IDX_W-1:0] slot;
   } beat_tag_type;

   typedef struct packed {
      logic         clear;
      beat_tag_type tag;
   } mac_ctrl_type;

endpackage
`default_nettype wire

[hdl/nearest_member_search.sv]
// A load beat leaves the block idle and ready for further beats.
// A search walks n members by dims coordinates, skipping the excluded member, then drains
// the pipeline and waits for a free result register, plus any wait on a held result; the
// block is ready again once the result is delivered. It reads one coordinate per cycle while
// scanning members other than the excluded one, through a single multiply-accumulate unit on one read port.
// Sync active-high reset clears control and the result valid flag; coordinates undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none
module nearest_member_search (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // member_slot, coord_slot, coord_value, exclude_slot
   input  wire logic [nms_pkg::REQ_DATA_W-1:0]     req_tdata,
   // mode
   input  wire logic [nms_pkg::MODE_W-1:0]         req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // nearest_slot, nearest_sq_distance, zero fill
   output logic      [nms_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [nms_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [nms_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic      [nms_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                    csr_pready
);
   import nms_pkg::*;

   logic [MEMBER_IDX_W-1:0] member_slot, exclude_slot;
   logic [DIM_IDX_W-1:0]    coord_slot;
   logic [COORD_BITS-1:0]   coord_value;
   mode_type                mode;
   logic                    req_beat, csr_wr, idle, deliver;
   reg_index_type           reg_idx;
   logic [COUNT_W-1:0]      member_count_ff;
   logic [DCOUNT_W-1:0]     dimension_count_ff;
   logic [MEM_ADDR_W-1:0]   mem_raddr;
   logic [DIM_IDX_W-1:0]    qry_raddr;
   logic [COORD_BITS-1:0]   mem_rdata, qry_rdata;
   mac_ctrl_type            ctrl;
   logic [MEMBER_IDX_W-1:0] best_slot;
   logic [DIST_W-1:0]       best_distance;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [MEMBER_IDX_W-1:0] rsp_slot_ff;
   logic [DIST_W-1:0]       rsp_dist_ff;

   assign member_slot  = req_tdata[MEMBER_IDX_W-1:0];
   assign coord_slot   = req_tdata[MEMBER_IDX_W +: DIM_IDX_W];
   assign coord_value  = req_tdata[MEMBER_IDX_W + DIM_IDX_W +: COORD_BITS];
   assign exclude_slot = req_tdata[MEMBER_IDX_W + DIM_IDX_W + COORD_BITS +: MEMBER_IDX_W];
   assign mode         = mode_type'(req_tuser);

   assign req_tready = idle;
   assign req_beat   = req_tvalid && req_tready;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_idx    = reg_index_type'(csr_paddr[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         member_count_ff    <= COUNT_W'(MAX_MEMBERS);
         dimension_count_ff <= DCOUNT_W'(MAX_DIMS);
      end else if (csr_wr) begin
         case (reg_idx)
            REG_MEMBER_COUNT:    member_count_ff    <= csr_pwdata[COUNT_W-1:0];
            REG_DIMENSION_COUNT: dimension_count_ff <= csr_pwdata[DCOUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_MEMBER_COUNT:    csr_prdata = CSR_DATA_W'(member_count_ff);
         REG_DIMENSION_COUNT: csr_prdata = CSR_DATA_W'(dimension_count_ff);
         default:             csr_prdata = '0;
      endcase
   end

   nms_store u_store (
      .clock     (clock),
      .mem_we    (req_beat && (mode == MODE_LOAD_MEMBER)),
      .mem_waddr ({member_slot, coord_slot}),
      .qry_we    (req_beat && (mode == MODE_LOAD_QUERY)),
      .qry_waddr (coord_slot),
      .wdata     (coord_value),
      .mem_raddr (mem_raddr),
      .qry_raddr (qry_raddr),
      .mem_rdata (mem_rdata),
      .qry_rdata (qry_rdata)
   );

   nms_seq u_seq (
      .clock           (clock),
      .reset           (reset),
      .start_search    (req_beat && (mode == MODE_SEARCH)),
      .member_count    (member_count_ff),
      .dimension_count (dimension_count_ff),
      .exclude_slot    (exclude_slot),
      .rsp_free        (!rsp_valid_ff || rsp_tready),
      .idle            (idle),
      .deliver         (deliver),
      .mem_raddr       (mem_raddr),
      .qry_raddr       (qry_raddr),
      .ctrl            (ctrl)
   );

   nms_mac u_mac (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .mem_rdata     (mem_rdata),
      .qry_rdata     (qry_rdata),
      .best_slot     (best_slot),
      .best_distance (best_distance)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (deliver) begin
         rsp_slot_ff <= best_slot;
         rsp_dist_ff <= best_distance;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'({rsp_dist_ff, rsp_slot_ff});

endmodule
`default_nettype wire

[hdl/nms_store.sv]
// member and query coordinate memories with registered reads
`timescale 1ns / 1ps
`default_nettype none
module nms_store (
   input  wire logic                             clock,
   input  wire logic                             mem_we,
   input  wire logic [nms_pkg::MEM_ADDR_W-1:0]   mem_waddr,
   input  wire logic                             qry_we,
   input  wire logic [nms_pkg::DIM_IDX_W-1:0]    qry_waddr,
   input  wire logic [nms_pkg::COORD_BITS-1:0]   wdata,
   input  wire logic [nms_pkg::MEM_ADDR_W-1:0]   mem_raddr,
   input  wire logic [nms_pkg::DIM_IDX_W-1:0]    qry_raddr,
   output logic      [nms_pkg::COORD_BITS-1:0]   mem_rdata,
   output logic      [nms_pkg::COORD_BITS-1:0]   qry_rdata
);
   import nms_pkg::*;

   logic [COORD_BITS-1:0] member_mem [MEM_DEPTH];
   logic [COORD_BITS-1:0] query_mem  [MAX_DIMS];
   logic [COORD_BITS-1:0] mem_rdata_ff;
   logic [COORD_BITS-1:0] qry_rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         member_mem[mem_waddr] <= wdata;
      end
      mem_rdata_ff <= member_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (qry_we) begin
         query_mem[qry_waddr] <= wdata;
      end
      qry_rdata_ff <= query_mem[qry_raddr];
   end

   assign mem_rdata = mem_rdata_ff;
   assign qry_rdata = qry_rdata_ff;

endmodule
`default_nettype wire

[hdl/nms_mac.sv]
// shared difference, square, accumulate and compare unit
`timescale 1ns / 1ps
`default_nettype none
module nms_mac (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire nms_pkg::mac_ctrl_type              ctrl,
   input  wire logic [nms_pkg::COORD_BITS-1:0]     mem_rdata,
   input  wire logic [nms_pkg::COORD_BITS-1:0]     qry_rdata,
   output logic      [nms_pkg::MEMBER_IDX_W-1:0]   best_slot,
   output logic      [nms_pkg::DIST_W-1:0]         best_distance
);
   import nms_pkg::*;

   beat_tag_type             tag0_ff, tag1_ff, tag2_ff;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [SQ_W-1:0]   prod;
   logic [SQ_W-1:0]          sq_ff;
   logic [DIST_W-1:0]        acc_ff, acc_in;
   logic [DIST_W-1:0]        best_dist_ff, best_dist_in;
   logic [MEMBER_IDX_W-1:0]  best_slot_ff, best_slot_in;
   logic                     have_best_ff, have_best_in;
   logic                     take;

   // stage 1: exact difference
   assign diff_in = $signed({qry_rdata[COORD_BITS-1], qry_rdata})
                  - $signed({mem_rdata[COORD_BITS-1], mem_rdata});
   // stage 2: square
   assign prod = diff_ff * diff_ff;

   // stage 3: accumulate and compare
   always_comb begin
      acc_in = (tag2_ff.first_dim ? '0 : acc_ff) + DIST_W'(sq_ff);
      take = tag2_ff.valid && tag2_ff.last_dim &&
             (!have_best_ff || (acc_in < best_dist_ff) ||
              ((acc_in == best_dist_ff) && tag2_ff.is_start));
      best_dist_in = take ? acc_in : best_dist_ff;
      best_slot_in = take ? tag2_ff.slot : best_slot_ff;
      have_best_in = ctrl.clear ? 1'b0 : (have_best_ff || take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff      <= '0;
         tag1_ff      <= '0;
         tag2_ff      <= '0;
         have_best_ff <= 1'b0;
         best_dist_ff <= '0;
         best_slot_ff <= '0;
      end else begin
         tag0_ff      <= ctrl.tag;
         tag1_ff      <= tag0_ff;
         tag2_ff      <= tag1_ff;
         have_best_ff <= have_best_in;
         best_dist_ff <= best_dist_in;
         best_slot_ff <= best_slot_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff <= diff_in;
      sq_ff   <= $unsigned(prod);
      if (tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign best_slot     = best_slot_ff;
   assign best_distance = best_dist_ff;

endmodule
`default_nettype wire

[hdl/nms_seq.sv]
// search sequencer: walks members and coordinates through the shared unit
`timescale 1ns / 1ps
`default_nettype none
module nms_seq (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start_search,
   input  wire logic [nms_pkg::COUNT_W-1:0]        member_count,
   input  wire logic [nms_pkg::DCOUNT_W-1:0]       dimension_count,
   input  wire logic [nms_pkg::MEMBER_IDX_W-1:0]   exclude_slot,
   input  wire logic                               rsp_free,
   output logic                                    idle,
   output logic                                    deliver,
   output logic      [nms_pkg::MEM_ADDR_W-1:0]     mem_raddr,
   output logic      [nms_pkg::DIM_IDX_W-1:0]      qry_raddr,
   output nms_pkg::mac_ctrl_type                   ctrl
);
   import nms_pkg::*;
   `include "nearest_member_search_assert.svh"

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [COUNT_W-1:0]      n_ff, n_in, n_clamp;
   logic [DCOUNT_W-1:0]     dims_ff, dims_in, dims_clamp;
   logic [MEMBER_IDX_W-1:0] ex_ff, ex_in;
   logic [MEMBER_IDX_W-1:0] start_ff, start_in;
   logic [MEMBER_IDX_W-1:0] i_ff, i_in;
   logic [DIM_IDX_W-1:0]    d_ff, d_in;
   logic [DRAIN_W-1:0]      drain_ff, drain_in;
   logic [COUNT_W-1:0]      ex_wide;
   logic                    skip, last_dim, last_member;

   always_comb begin
      if (member_count < COUNT_W'(2)) begin
         n_clamp = COUNT_W'(2);
      end else if (member_count > COUNT_W'(MAX_MEMBERS)) begin
         n_clamp = COUNT_W'(MAX_MEMBERS);
      end else begin
         n_clamp = member_count;
      end
      if (dimension_count < DCOUNT_W'(1)) begin
         dims_clamp = DCOUNT_W'(1);
      end else if (dimension_count > DCOUNT_W'(MAX_DIMS)) begin
         dims_clamp = DCOUNT_W'(MAX_DIMS);
      end else begin
         dims_clamp = dimension_count;
      end
      ex_wide = COUNT_W'(exclude_slot);
      // tie winner: lower neighbor of the excluded member, upper for member 0, member 0 if out of range
      if (ex_wide == n_clamp - COUNT_W'(1)) begin
         start_in = MEMBER_IDX_W'(n_clamp - COUNT_W'(2));
      end else if (exclude_slot == '0) begin
         start_in = MEMBER_IDX_W'(1);
      end else if (ex_wide < n_clamp) begin
         start_in = exclude_slot - MEMBER_IDX_W'(1);
      end else begin
         start_in = '0;
      end
   end

   assign skip        = (i_ff == ex_ff);
   assign last_dim    = (DCOUNT_W'(d_ff) == dims_ff - DCOUNT_W'(1));
   assign last_member = (COUNT_W'(i_ff) == n_ff - COUNT_W'(1));

   always_comb begin
      state_in = state_ff;
      n_in     = n_ff;
      dims_in  = dims_ff;
      ex_in    = ex_ff;
      i_in     = i_ff;
      d_in     = d_ff;
      drain_in = drain_ff;
      deliver  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start_search) begin
               n_in     = n_clamp;
               dims_in  = dims_clamp;
               ex_in    = exclude_slot;
               i_in     = '0;
               d_in     = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (skip || last_dim) begin
               d_in = '0;
               if (last_member) begin
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + MEMBER_IDX_W'(1);
               end
            end else begin
               d_in = d_ff + DIM_IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            drain_in = drain_ff + DRAIN_W'(1);
            if (drain_ff == DRAIN_LAST) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               deliver  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         d_ff     <= '0;
         drain_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         d_ff     <= d_in;
         drain_ff <= drain_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      dims_ff <= dims_in;
      ex_ff   <= ex_in;
      if ((state_ff == ST_IDLE) && start_search) begin
         start_ff <= start_in;
      end
   end

   always_comb begin
      ctrl.clear         = (state_ff == ST_IDLE) && start_search;
      ctrl.tag.valid     = (state_ff == ST_SCAN) && !skip;
      ctrl.tag.first_dim = (d_ff == '0);
      ctrl.tag.last_dim  = last_dim;
      ctrl.tag.is_start  = (i_ff == start_ff);
      ctrl.tag.slot      = i_ff;
   end

   assign mem_raddr = {i_ff, d_ff};
   assign qry_raddr = d_ff;
   assign idle      = (state_ff == ST_IDLE);

   `NMS_ASSERT_NXT(a_search_starts_scan, clock, reset,
      (state_ff == ST_IDLE) && start_search, state_ff == ST_SCAN,
      "search did not enter scan")
   `NMS_ASSERT_IMP(a_excluded_never_read, clock, reset,
      ctrl.tag.valid, ctrl.tag.slot != ex_ff, "excluded member was read")
   `NMS_ASSERT_IMP(a_member_in_range, clock, reset,
      state_ff == ST_SCAN, COUNT_W'(i_ff) < n_ff, "member index past count")
   `NMS_ASSERT_IMP(a_dim_in_range, clock, reset,
      state_ff == ST_SCAN, DCOUNT_W'(d_ff) < dims_ff, "coordinate index past count")

endmodule
`default_nettype wire
